// ===== hdl/scfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scfc_pkg;

    // frame layout
    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'h55;
    localparam int unsigned HEADER_BYTES = 3;
    localparam int unsigned CRC_BYTES    = 4;

    // crc-32, reflected ieee form
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

    // byte counter
    localparam int unsigned COUNT_W   = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // configuration reset value
    localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd100;

    // verdict codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEN   = 2'd1,
        ST_BAD_SYNC  = 2'd2,
        ST_BAD_CRC   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        frame_pass;
        logic [1:0]  status;
        logic [31:0] computed_crc;
    } t_out_item;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sync_crc32_frame_checker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame checker for sync-framed byte streams: 0xAA, 0x55, a length byte (ignored),
// payload_length payload bytes and a CRC-32 (reflected IEEE, low byte first) over the
// payload. One byte is taken every clock while o_in_ready is high; the CRC update is an
// unrolled eight-bit step. The verdict for the marked last byte is registered into the
// output register, or into a one-entry skid stage behind it; the skid stage lets input
// continue while a verdict waits, and input stalls only when both are full.
// Status: 0 ok, 1 wrong length (checked first), 2 bad sync, 3 CRC mismatch.
// Write payload_length only while no frame is in progress.
module sync_crc32_frame_checker_unit
    import scfc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // input byte channel
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    // verdict channel
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    // configuration
    input  wire logic      i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data
);

    logic [7:0]         r_payload_length;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [31:0]        r_running_crc, n_running_crc;
    logic               r_sync_error, n_sync_error;
    logic [31:0]        r_received_crc, n_received_crc;

    logic               r_out_valid;
    t_out_item          r_out_data;
    logic               r_skid_valid;
    t_out_item          r_skid_data;

    logic               in_xfer;
    logic               out_xfer;
    logic [COUNT_W-1:0] crc_start;
    logic [COUNT_W-1:0] total_len;
    logic [COUNT_W-1:0] crc_offset;
    logic [31:0]        calc_crc;
    t_status            status;
    t_out_item          result;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // frame positions from the configured length
    assign crc_start  = COUNT_W'(HEADER_BYTES) + {1'b0, r_payload_length};
    assign total_len  = crc_start + COUNT_W'(CRC_BYTES);
    assign crc_offset = r_byte_count - crc_start;

    // per-byte state update
    always_comb begin
        n_running_crc  = r_running_crc;
        n_sync_error   = r_sync_error;
        n_received_crc = r_received_crc;
        if (r_byte_count == '0) begin
            if (i_in_data.byte_value != SYNC_FIRST) begin
                n_sync_error = 1'b1;
            end
        end else if (r_byte_count == COUNT_W'(1)) begin
            if (i_in_data.byte_value != SYNC_SECOND) begin
                n_sync_error = 1'b1;
            end
        end else if (r_byte_count >= COUNT_W'(HEADER_BYTES) && r_byte_count < crc_start) begin
            n_running_crc = crc_byte(r_running_crc, i_in_data.byte_value);
        end else if (r_byte_count >= crc_start && r_byte_count < total_len) begin
            case (crc_offset[1:0])
                2'd0:    n_received_crc[7:0]   = i_in_data.byte_value;
                2'd1:    n_received_crc[15:8]  = i_in_data.byte_value;
                2'd2:    n_received_crc[23:16] = i_in_data.byte_value;
                default: n_received_crc[31:24] = i_in_data.byte_value;
            endcase
        end
        n_byte_count = (r_byte_count < COUNT_MAX) ? r_byte_count + COUNT_W'(1) : r_byte_count;
    end

    // verdict for the last byte
    always_comb begin
        calc_crc = n_running_crc ^ CRC_XOROUT;
        if (n_byte_count != total_len) begin
            status = ST_BAD_LEN;
        end else if (n_sync_error) begin
            status = ST_BAD_SYNC;
        end else if (n_received_crc != calc_crc) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
        result.frame_pass   = (status == ST_OK);
        result.status       = status;
        result.computed_crc = calc_crc;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= PAYLOAD_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_payload_length <= i_cfg_wr_data;
        end
    end

    // frame state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_running_crc  <= CRC_INIT;
            r_sync_error   <= 1'b0;
            r_received_crc <= '0;
        end else if (in_xfer) begin
            if (i_in_data.frame_end) begin
                r_byte_count   <= '0;
                r_running_crc  <= CRC_INIT;
                r_sync_error   <= 1'b0;
                r_received_crc <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_running_crc  <= n_running_crc;
                r_sync_error   <= n_sync_error;
                r_received_crc <= n_received_crc;
            end
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_xfer && i_in_data.frame_end) begin
            // skid is empty here since input is ready
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output stages
    always_ff @(posedge i_clk) begin
        if (out_xfer && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
        if (in_xfer && i_in_data.frame_end) begin
            if (!r_out_valid || (out_xfer && !r_skid_valid)) begin
                r_out_data <= result;
            end else begin
                r_skid_data <= result;
            end
        end
    end

`ifndef SYNTHESIS
    // skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a verdict while output register is empty");

    // verdict code and pass flag agree
    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.frame_pass == (r_out_data.status == ST_OK)))
        else $error("pass flag disagrees with status");

    // frame state returns to reset values after the last byte
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.frame_end) |=>
            (r_byte_count == '0 && r_running_crc == CRC_INIT && !r_sync_error))
        else $error("frame state not cleared after last byte");

    // a last byte always yields a pending verdict
    a_end_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.frame_end) |=> r_out_valid)
        else $error("last byte transfer produced no verdict");
`endif

endmodule

`default_nettype wire

// ===== dv/scfc_verdict_checker.sv =====
`timescale 1ns / 1ps

// watches both channels of the frame checker, predicts each verdict and compares
module scfc_verdict_checker
    import scfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte channel
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire t_in_item   i_in_data,
    // verdict channel
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_out_item  i_out_data,
    // configuration
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    // status for the testbench top
    output int              o_mismatch_count,
    output int              o_verdicts_pending
);

    // predicted copy of the register and the frame state
    logic [7:0]         payload_len;
    logic [COUNT_W-1:0] byte_count;
    logic [31:0]        run_crc;
    logic               sync_bad;
    logic [31:0]        rx_crc;

    t_out_item expected_verdicts[$];
    int        mismatch_count;

    // bitwise reflected crc-32 step
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ data[k]}});
        end
        return c;
    endfunction

    task automatic clear_frame();
        byte_count = '0;
        run_crc    = CRC_INIT;
        sync_bad   = 1'b0;
        rx_crc     = '0;
    endtask

    // one byte through the predicted frame state, verdict on the marked last byte
    task automatic predict_frame_byte(input t_in_item item);
        int unsigned pos;
        int unsigned crc_begin;
        int unsigned frame_total;
        t_status     verdict;
        t_out_item   v;
        logic [31:0] crc_final;
        pos         = byte_count;
        crc_begin   = HEADER_BYTES + payload_len;
        frame_total = crc_begin + CRC_BYTES;
        if (pos == 0) begin
            if (item.byte_value != SYNC_FIRST) sync_bad = 1'b1;
        end else if (pos == 1) begin
            if (item.byte_value != SYNC_SECOND) sync_bad = 1'b1;
        end else if (pos >= HEADER_BYTES && pos < crc_begin) begin
            run_crc = crc_update(run_crc, item.byte_value);
        end else if (pos >= crc_begin && pos < frame_total) begin
            rx_crc[8*(pos-crc_begin) +: 8] = item.byte_value;
        end
        // count stops at its maximum on overlong frames
        if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
        if (item.frame_end) begin
            crc_final = run_crc ^ CRC_XOROUT;
            if (byte_count != frame_total) begin
                verdict = ST_BAD_LEN;
            end else if (sync_bad) begin
                verdict = ST_BAD_SYNC;
            end else if (rx_crc != crc_final) begin
                verdict = ST_BAD_CRC;
            end else begin
                verdict = ST_OK;
            end
            v.frame_pass   = (verdict == ST_OK);
            v.status       = verdict;
            v.computed_crc = crc_final;
            expected_verdicts.insert(expected_verdicts.size(), v);
            clear_frame();
        end
    endtask

    task automatic flag_verdict(input string why, input t_out_item want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected ok=%0d status=%0d crc=%08h, got ok=%0d status=%0d crc=%08h",
                     $realtime, why, want.frame_pass, want.status, want.computed_crc,
                     i_out_data.frame_pass, i_out_data.status, i_out_data.computed_crc);
        end
    endtask

    // sample at the rising edge: register write, byte transfer, verdict transfer
    always @(posedge i_clk) begin : verdict_check
        t_out_item want;
        if (!i_rst_n) begin
            payload_len = PAYLOAD_LENGTH_RESET;
            clear_frame();
            expected_verdicts.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_wr_en) payload_len = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) predict_frame_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    flag_verdict("verdict with none pending", '0);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (want.frame_pass != i_out_data.frame_pass
                            || want.status != i_out_data.status
                            || want.computed_crc != i_out_data.computed_crc) begin
                        flag_verdict("verdict mismatch", want);
                    end
                end
            end
        end
        o_mismatch_count   = mismatch_count;
        o_verdicts_pending = expected_verdicts.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import scfc_pkg::*;
();

    localparam int GAP_MAX     = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_BYTES = 16;
    localparam int HOLD_BYTES  = 48;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_SYNC,
        FRAME_SHORT,
        FRAME_LONG,
        FRAME_NOISE
    } t_frame_kind;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       o_in_ready;
    t_in_item   in_data;
    logic       o_out_valid;
    logic       out_ready;
    t_out_item  o_out_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int mismatch_count;
    int verdicts_pending;

    // stimulus knobs, some shared with the receiver process
    int         tx_gap_max;
    int         rx_gap_max;
    int         rx_hold_req;
    logic [7:0] cur_len;
    logic [7:0] frame_bytes[$];
    logic [7:0] frame_copy[$];
    int         stall_cycles;

    sync_crc32_frame_checker_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    scfc_verdict_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (o_in_ready),
        .i_in_data          (in_data),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .i_out_data         (o_out_data),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .o_mismatch_count   (mismatch_count),
        .o_verdicts_pending (verdicts_pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on cycles without any transfer
    initial stall_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // idle cycles before one transfer, often none
    function automatic int draw_gap(input int gap_max);
        if (gap_max == 0 || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, gap_max);
    endfunction

    // crc of frame payloads for building well-formed frames
    function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // receiver: random stalls per verdict, one long hold-off on request
    initial begin : verdict_sink
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (rx_hold_req > 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_req) @(negedge clk);
                rx_hold_req = 0;
            end
            gap = draw_gap(rx_gap_max);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid && out_ready));
        end
    end

    // one byte transfer; valid stays high afterwards for back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap(tx_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        do @(posedge clk); while (!o_in_ready);
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // register write once the block has drained every verdict
    task automatic set_payload_length(input logic [7:0] len);
        in_valid <= 1'b0;
        while (verdicts_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_len = len;
    endtask

    // frame at the current length, fill < 0 gives random payload
    task automatic build_frame(input t_frame_kind kind, input int fill);
        logic [31:0] crc;
        logic [7:0]  b;
        int          idx;
        frame_bytes = {};
        frame_bytes.insert(frame_bytes.size(), SYNC_FIRST);
        frame_bytes.insert(frame_bytes.size(), SYNC_SECOND);
        frame_bytes.insert(frame_bytes.size(), 8'($urandom));
        crc = CRC_INIT;
        for (int i = 0; i < cur_len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            frame_bytes.insert(frame_bytes.size(), b);
            crc = crc_next(crc, b);
        end
        crc = crc ^ CRC_XOROUT;
        for (int i = 0; i < CRC_BYTES; i++) frame_bytes.insert(frame_bytes.size(), crc[8*i +: 8]);
        case (kind)
            FRAME_BAD_CRC: begin
                idx = frame_bytes.size() - 1 - $urandom_range(0, 3);
                frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            FRAME_BAD_SYNC: begin
                idx = $urandom_range(0, 1);
                frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
                // sometimes the crc is broken too, sync must still win
                if ($urandom_range(0, 1)) frame_bytes[frame_bytes.size()-1] = ~frame_bytes[frame_bytes.size()-1];
            end
            FRAME_SHORT: begin
                repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
            end
            FRAME_LONG: begin
                repeat ($urandom_range(1, 6)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
            end
            FRAME_NOISE: begin
                frame_bytes = {};
                repeat ($urandom_range(1, 16)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return FRAME_GOOD;
        if (r < 70) return FRAME_BAD_CRC;
        if (r < 78) return FRAME_BAD_SYNC;
        if (r < 86) return FRAME_SHORT;
        if (r < 93) return FRAME_LONG;
        return FRAME_NOISE;
    endfunction

    // stimulus and verdict
    initial begin : stimulus
        int sent;
        int target;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        tx_gap_max  = GAP_MAX;
        rx_gap_max  = GAP_MAX;
        rx_hold_req = 0;
        cur_len     = PAYLOAD_LENGTH_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // good frame at the length out of reset
        build_frame(FRAME_GOOD, -1);
        send_frame();

        // empty payload: crc of nothing, bad sync, single-byte frame
        set_payload_length(8'd0);
        build_frame(FRAME_GOOD, -1);
        send_frame();
        build_frame(FRAME_BAD_SYNC, -1);
        send_frame();
        frame_bytes = {SYNC_FIRST};
        send_frame();

        // one-byte payload: all-zero and all-one data, bad crc, short and long frames
        set_payload_length(8'd1);
        build_frame(FRAME_GOOD, 8'h00);
        send_frame();
        build_frame(FRAME_GOOD, 8'hFF);
        send_frame();
        build_frame(FRAME_BAD_CRC, -1);
        send_frame();
        build_frame(FRAME_SHORT, -1);
        send_frame();
        build_frame(FRAME_LONG, -1);
        send_frame();

        // overlong frame: 512 bytes past a valid frame, so a wrapping count would pass it
        build_frame(FRAME_GOOD, -1);
        frame_copy = frame_bytes;
        frame_bytes = {};
        repeat (65) begin
            for (int i = 0; i < frame_copy.size(); i++) begin
                frame_bytes.insert(frame_bytes.size(), frame_copy[i]);
            end
        end
        send_frame();

        // random phases at several lengths
        for (int ph = 0; ph < 8; ph++) begin
            target = PHASE_BYTES;
            case (ph)
                0: begin
                    set_payload_length(8'd255);
                    target = 1;
                end
                1: set_payload_length(8'd1);
                2: begin
                    set_payload_length(8'd1);
                    target = HOLD_BYTES;
                end
                default: set_payload_length(8'($urandom_range(2, 12)));
            endcase
            tx_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
            rx_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
            // long receiver hold-off while short frames keep coming
            if (ph == 2) begin
                tx_gap_max  = 0;
                rx_gap_max  = 0;
                rx_hold_req = HOLD_CYCLES;
            end
            sent = 0;
            while (sent < target) begin
                build_frame(pick_kind(), -1);
                send_frame();
                sent += frame_bytes.size();
            end
        end

        in_valid <= 1'b0;
        while (verdicts_pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
        if (mismatch_count == 0 && verdicts_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/scfc_pkg.sv
hdl/sync_crc32_frame_checker_unit.sv
dv/scfc_verdict_checker.sv
dv/tb_top.sv
